FILE: sv/assert_macros.svh
// Assertion macros used by the depth buffer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ppdb_pkg.sv
// Types and constants of the point projection depth buffer.
package ppdb_pkg;

	typedef struct packed {
		logic              op;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
		logic [5:0]        read_row;
		logic [8:0]        read_col;
	} pt_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  pixel_row;
		logic [8:0]  pixel_col;
		logic [15:0] depth_value;
	} res_word_t;

	typedef struct packed {
		logic        start;
		logic        sqrt;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
	} alu_rsp_t;

	localparam logic OP_READ = 1'b1;

	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_FARTHER = 3'd1;
	localparam logic [2:0] ST_OUTSIDE = 3'd2;
	localparam logic [2:0] ST_BEHIND  = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;

	localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
	localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
	localparam logic [2:0] CFG_CENTER_X = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y = 3'd3;
	localparam logic [2:0] CFG_MAX_DEP  = 3'd4;
	localparam logic [2:0] CFG_SENS_W   = 3'd5;
	localparam logic [2:0] CFG_SENS_H   = 3'd6;
	localparam logic [2:0] CFG_ROW_OFS  = 3'd7;

	localparam logic [31:0] RST_FOCAL_X  = 32'd243740180;
	localparam logic [31:0] RST_FOCAL_Y  = 32'd243782779;
	localparam logic [31:0] RST_CENTER_X = 32'd125544694;
	localparam logic [31:0] RST_CENTER_Y = 32'd70305055;
	localparam logic [31:0] RST_MAX_DEP  = 32'd6553600;
	localparam logic [15:0] RST_SENS_W   = 16'd3840;
	localparam logic [15:0] RST_SENS_H   = 16'd2160;
	localparam logic [9:0]  RST_ROW_OFS  = 10'd30;

	localparam logic [63:0] PROJ_LIMIT = 64'h0000_0100_0000_0000;
	localparam logic [63:0] SQRT_BIT0  = 64'h4000_0000_0000_0000;
	localparam logic [5:0]  DIV_LAST   = 6'd63;
	localparam logic [5:0]  SQRT_LAST  = 6'd31;
	localparam logic [15:0] DEPTH_MAX  = 16'hFFFF;

endpackage

FILE: sv/ppdb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppdb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 14400,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/ppdb_alu.sv
// Shared iterative unit: restoring divide (64 steps) and integer square root (32 steps).
module ppdb_alu import ppdb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic        busy_q, done_q, sqrt_q;
	logic [5:0]  cnt_q;
	logic [63:0] a_q, b_q, r_q, q_q;
	logic [63:0] shl, op1, op2;
	logic [64:0] diff;
	logic        ge;

	// one subtractor serves both modes
	always_comb begin
		shl  = {r_q[62:0], a_q[63]};
		op1  = sqrt_q ? a_q : shl;
		op2  = sqrt_q ? (r_q + b_q) : b_q;
		diff = {1'b0, op1} - {1'b0, op2};
		ge   = !diff[64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sqrt_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				sqrt_q <= req.sqrt;
				cnt_q  <= req.sqrt ? SQRT_LAST : DIV_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.sqrt ? SQRT_BIT0 : req.b;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			if (sqrt_q) begin
				if (ge) begin
					a_q <= diff[63:0];
				end
				r_q <= ge ? ((r_q >> 1) + b_q) : (r_q >> 1);
				b_q <= b_q >> 2;
			end else begin
				a_q <= {a_q[62:0], 1'b0};
				r_q <= ge ? diff[63:0] : shl;
				q_q <= {q_q[62:0], ge};
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = sqrt_q ? r_q : q_q;

endmodule

FILE: sv/point_projection_depth_buffer.sv
// Top level: pinhole projection of points into a nearest-range depth grid.
//
// Channels: pt/pt_valid/pt_stall carries one input word (insert or read);
// res/res_valid/res_stall returns exactly one result word per input word.
// A word moves on a rising edge with valid high and stall low.
// cfg_we/cfg_index/cfg_data writes one register per edge; the user must write
// only while idle, which the block itself does not enforce.
// Throughput: one word at a time; pt_stall is low only in the idle state.
// An insert runs through the shared divide/root unit: five 64-step
// divides (two projections, column, row, depth) and one 32-step square
// root, plus multiply and bookkeeping states. A point behind the camera
// goes straight to the output state; an in-range read first reads the store.
//
// Reset: configuration registers take their defaults, then a clearing pass
// zeroes the depth store one cell a cycle (STORE_ROWS x GRID_WIDTH cells,
// 14400 at the defaults); pt_stall stays high until it ends.
//
// A result waits in the output register while res_stall is high; the
// block may accept and work on the next word meanwhile, and holds in its
// final state until the output register frees.
`include "assert_macros.svh"

module point_projection_depth_buffer import ppdb_pkg::*; #(
	parameter int GRID_WIDTH  = 320,
	parameter int GRID_HEIGHT = 102,
	parameter int KEPT_ROWS   = 45
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pt_valid,
	output logic      pt_stall,
	input  pt_word_t  pt,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int STORE_ROWS = (KEPT_ROWS < GRID_HEIGHT) ? KEPT_ROWS : GRID_HEIGHT;
	localparam int DEPTH      = STORE_ROWS * GRID_WIDTH;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W      = $clog2(GRID_WIDTH);
	localparam int ROW_W      = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
	localparam logic signed [63:0] GW_S = 64'(GRID_WIDTH);
	localparam logic signed [63:0] GH_S = 64'(GRID_HEIGHT);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	typedef enum logic [24:0] {
		S_CLR  = 25'h0000001,
		S_IDLE = 25'h0000002,
		S_RA   = 25'h0000004,
		S_RB   = 25'h0000008,
		S_MX   = 25'h0000010,
		S_DX   = 25'h0000020,
		S_WX   = 25'h0000040,
		S_MY   = 25'h0000080,
		S_DY   = 25'h0000100,
		S_WY   = 25'h0000200,
		S_MRO  = 25'h0000400,
		S_DC   = 25'h0000800,
		S_WC   = 25'h0001000,
		S_DR   = 25'h0002000,
		S_WR   = 25'h0004000,
		S_SX   = 25'h0008000,
		S_SY   = 25'h0010000,
		S_SZ   = 25'h0020000,
		S_SS   = 25'h0040000,
		S_QS   = 25'h0080000,
		S_WQ   = 25'h0100000,
		S_DD   = 25'h0200000,
		S_WD   = 25'h0400000,
		S_CMP  = 25'h0800000,
		S_OUT  = 25'h1000000
	} state_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (~v + 64'd1) : v;
	endfunction

	// configuration registers
	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q, max_depth_q;
	logic [15:0] sensor_width_q, sensor_height_q;
	logic [9:0]  row_offset_q;

	state_t      state_q;
	logic [AW-1:0] clr_q, addr_q;
	logic        res_valid_q, neg_q, col_ok_q;
	res_word_t   res_q, word_q;

	// working registers
	logic signed [31:0] x_q, y_q, z_q;
	logic signed [63:0] prod_q, u_q, v_q;
	logic [25:0]  rofs_q;
	logic [63:0]  sum_q;
	logic [31:0]  rng_q;
	logic [15:0]  nd_q;
	logic [COL_W-1:0] col_idx_q;
	logic [5:0]   pix_row_q;
	logic [8:0]   pix_col_q;

	// shared multiplier and datapath helpers
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_full;
	logic [15:0]  sw_eff, sh_eff;
	logic [31:0]  md_eff;
	logic signed [63:0] col_num, row_num, qsat;
	logic [63:0]  sat;
	logic         row_ok, store_new, out_free, accept;
	logic         in_wait, out_blocked;
	alu_req_t     alu_req;
	alu_rsp_t     alu_rsp;
	logic         ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]  ram_wdata, ram_rdata;

	assign sw_eff = (sensor_width_q == 16'd0) ? 16'd1 : sensor_width_q;
	assign sh_eff = (sensor_height_q == 16'd0) ? 16'd1 : sensor_height_q;
	assign md_eff = (max_depth_q == 32'd0) ? 32'd1 : max_depth_q;

	assign pt_stall  = (state_q != S_IDLE);
	assign accept    = pt_valid && !pt_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q       <= RST_FOCAL_X;
			focal_y_q       <= RST_FOCAL_Y;
			center_x_q      <= RST_CENTER_X;
			center_y_q      <= RST_CENTER_Y;
			max_depth_q     <= RST_MAX_DEP;
			sensor_width_q  <= RST_SENS_W;
			sensor_height_q <= RST_SENS_H;
			row_offset_q    <= RST_ROW_OFS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FOCAL_X:  focal_x_q       <= cfg_data;
				CFG_FOCAL_Y:  focal_y_q       <= cfg_data;
				CFG_CENTER_X: center_x_q      <= cfg_data;
				CFG_CENTER_Y: center_y_q      <= cfg_data;
				CFG_MAX_DEP:  max_depth_q     <= cfg_data;
				CFG_SENS_W:   sensor_width_q  <= cfg_data[15:0];
				CFG_SENS_H:   sensor_height_q <= cfg_data[15:0];
				CFG_ROW_OFS:  row_offset_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// multiplier operands; product registered before any use
	always_comb begin
		unique case (state_q)
			S_MX: begin
				mul_a = {1'b0, focal_x_q};
				mul_b = {x_q[31], x_q};
			end
			S_MY: begin
				mul_a = {1'b0, focal_y_q};
				mul_b = {y_q[31], y_q};
			end
			S_MRO: begin
				mul_a = {23'd0, row_offset_q};
				mul_b = {17'd0, sh_eff};
			end
			S_SX: begin
				mul_a = {x_q[31], x_q};
				mul_b = {x_q[31], x_q};
			end
			S_SY: begin
				mul_a = {y_q[31], y_q};
				mul_b = {y_q[31], y_q};
			end
			S_SZ: begin
				mul_a = {z_q[31], z_q};
				mul_b = {z_q[31], z_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_full = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= prod_full[63:0];
	end

	// dividends for the grid column and row
	assign col_num = u_q * GW_S;
	assign row_num = (v_q * GH_S) - $signed({22'd0, rofs_q, 16'd0});

	// divide / root requests
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			S_DX, S_DY: begin
				alu_req.start = 1'b1;
				alu_req.a     = mag64(prod_q);
				alu_req.b     = {32'd0, z_q};
			end
			S_DC: begin
				alu_req.start = 1'b1;
				alu_req.a     = mag64(col_num);
				alu_req.b     = {32'd0, sw_eff, 16'd0};
			end
			S_DR: begin
				alu_req.start = 1'b1;
				alu_req.a     = mag64(row_num);
				alu_req.b     = {32'd0, sh_eff, 16'd0};
			end
			S_QS: begin
				alu_req.start = 1'b1;
				alu_req.sqrt  = 1'b1;
				alu_req.a     = sum_q;
			end
			S_DD: begin
				alu_req.start = 1'b1;
				alu_req.a     = {16'd0, rng_q, 16'd0};
				alu_req.b     = {32'd0, md_eff};
			end
			default: ;
		endcase
	end

	ppdb_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// projection: truncate toward zero, then clamp to the projection limit
	assign sat  = (alu_rsp.value > PROJ_LIMIT) ? PROJ_LIMIT : alu_rsp.value;
	assign qsat = neg_q ? -$signed(sat) : $signed(sat);

	assign row_ok = (!neg_q || (alu_rsp.value == 64'd0)) &&
	                (alu_rsp.value < 64'(STORE_ROWS));
	assign store_new = (ram_rdata == 16'd0) || (nd_q < ram_rdata);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (pt.op == OP_READ) begin
							if ((32'(pt.read_row) < STORE_ROWS) &&
							    (32'(pt.read_col) < GRID_WIDTH)) begin
								state_q <= S_RA;
							end else begin
								state_q <= S_OUT;
							end
						end else if (pt.z_coord <= 32'sd0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_MX;
						end
					end
				end
				S_RA:  state_q <= S_RB;
				S_RB:  state_q <= S_OUT;
				S_MX:  state_q <= S_DX;
				S_DX:  state_q <= S_WX;
				S_WX:  if (alu_rsp.done) state_q <= S_MY;
				S_MY:  state_q <= S_DY;
				S_DY:  state_q <= S_WY;
				S_WY:  if (alu_rsp.done) state_q <= S_MRO;
				S_MRO: state_q <= S_DC;
				S_DC:  state_q <= S_WC;
				S_WC:  if (alu_rsp.done) state_q <= S_DR;
				S_DR:  state_q <= S_WR;
				S_WR: begin
					if (alu_rsp.done) begin
						state_q <= (row_ok && col_ok_q) ? S_SX : S_OUT;
					end
				end
				S_SX:  state_q <= S_SY;
				S_SY:  state_q <= S_SZ;
				S_SZ:  state_q <= S_SS;
				S_SS:  state_q <= S_QS;
				S_QS:  state_q <= S_WQ;
				S_WQ:  if (alu_rsp.done) state_q <= S_DD;
				S_DD:  state_q <= S_WD;
				S_WD:  if (alu_rsp.done) state_q <= S_CMP;
				S_CMP: state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			res_q <= word_q;
		end
		unique case (state_q)
			S_IDLE: begin
				x_q <= pt.x_coord;
				y_q <= pt.y_coord;
				z_q <= pt.z_coord;
				addr_q <= AW'((32'(pt.read_row) * GRID_WIDTH) + 32'(pt.read_col));
				if (pt.op == OP_READ) begin
					word_q <= '{status: ST_READ, pixel_row: 6'd0, pixel_col: 9'd0,
					            depth_value: 16'd0};
					pix_row_q <= pt.read_row;
					pix_col_q <= pt.read_col;
				end else begin
					word_q <= '{status: ST_BEHIND, pixel_row: 6'd0, pixel_col: 9'd0,
					            depth_value: 16'd0};
				end
			end
			S_RB: begin
				word_q <= '{status: ST_READ, pixel_row: pix_row_q, pixel_col: pix_col_q,
				            depth_value: ram_rdata};
			end
			S_DX, S_DY: neg_q <= prod_q[63];
			S_WX: if (alu_rsp.done) u_q <= qsat + $signed({32'd0, center_x_q});
			S_WY: if (alu_rsp.done) v_q <= qsat + $signed({32'd0, center_y_q});
			S_DC: begin
				neg_q  <= u_q[63];
				rofs_q <= prod_q[25:0];
			end
			S_WC: begin
				col_ok_q  <= (!neg_q || (alu_rsp.value == 64'd0)) &&
				             (alu_rsp.value < 64'(GRID_WIDTH));
				col_idx_q <= alu_rsp.value[COL_W-1:0];
				pix_col_q <= alu_rsp.value[8:0];
			end
			S_DR: neg_q <= row_num[63];
			S_WR: begin
				addr_q <= AW'((32'(alu_rsp.value[ROW_W-1:0]) * GRID_WIDTH) +
				              32'(col_idx_q));
				pix_row_q <= alu_rsp.value[5:0];
				word_q <= '{status: ST_OUTSIDE, pixel_row: 6'd0, pixel_col: 9'd0,
				            depth_value: 16'd0};
			end
			S_SY: sum_q <= prod_q;
			S_SZ, S_SS: sum_q <= sum_q + prod_q;
			S_WQ: begin
				rng_q <= (alu_rsp.value > 64'(md_eff)) ? md_eff : alu_rsp.value[31:0];
			end
			S_WD: begin
				if (alu_rsp.value > 64'(DEPTH_MAX)) begin
					nd_q <= DEPTH_MAX;
				end else if (alu_rsp.value == 64'd0) begin
					nd_q <= 16'd1;
				end else begin
					nd_q <= alu_rsp.value[15:0];
				end
			end
			S_CMP: begin
				word_q <= '{status: store_new ? ST_STORED : ST_FARTHER,
				            pixel_row: pix_row_q, pixel_col: pix_col_q, depth_value: nd_q};
			end
			default: ;
		endcase
	end

	// depth store: clearing pass, read-and-clear, and nearest-wins update
	assign ram_we    = (state_q == S_CLR) || (state_q == S_RB) ||
	                   ((state_q == S_CMP) && store_new);
	assign ram_waddr = (state_q == S_CLR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == S_CMP) ? nd_q : 16'd0;

	ppdb_ram #(
		.WIDTH (16),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// checks
	assign in_wait = (state_q == S_WX) || (state_q == S_WY) || (state_q == S_WC) ||
	                 (state_q == S_WR) || (state_q == S_WQ) || (state_q == S_WD);
	assign out_blocked = (state_q == S_OUT) && res_valid_q && res_stall;

	`ASSERT_IMPL(a_clr_stall, state_q == S_CLR, pt_stall, "word taken during clearing pass")
	`ASSERT_IMPL(a_done_wait, alu_rsp.done, in_wait, "unit finished outside a wait state")
	`ASSERT_IMPL(a_store_nz, ram_we && (state_q == S_CMP), ram_wdata != 16'd0, "empty depth")
	`ASSERT_NEXT(a_out_hold, out_blocked, state_q == S_OUT, "result dropped while output busy")

endmodule
